[rtl/core/cdet_pkg.sv]
// Package for the cofactor determinant block: field widths, register
// indexes and fixed-point constants. No dependencies.
package cdet_pkg;

    localparam int MAX_N_DEFAULT = 4;
    localparam int ELEM_W        = 32;
    localparam int DET_W         = 64;
    localparam int DIM_W         = 3;
    localparam int CFG_IDX_W     = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

    // Result for a shape that is not square, plain integer.
    localparam logic signed [DET_W-1:0] SENTINEL = -64'sd999999;
    // 1.0 in Q16.16, the determinant of the empty minor.
    localparam logic signed [DET_W-1:0] Q_ONE    = 64'sd65536;
    localparam logic signed [DET_W-1:0] DET_MAX  = {1'b0, {(DET_W-1){1'b1}}};
    localparam logic signed [DET_W-1:0] DET_MIN  = {1'b1, {(DET_W-1){1'b0}}};

endpackage

[rtl/core/cofactor_determinant.sv]
// Cofactor determinant top level: element load, minor sequencer and one shared
// 32x32 multiplier. Depends on cdet_pkg.
// Elements load one per cycle while busy is low. After the closing element of an
// n x n matrix, busy stays high until every minor is built; done strobes as it drops.
// A non-square shape strobes done the cycle after its closing element, never busy.
// The receiver cannot stall. Reset clears control; the store is undefined.
module cofactor_determinant
    import cdet_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [ELEM_W-1:0] elem_value,
    input  logic                     last_elem,
    output logic                     done,
    output logic signed [DET_W-1:0]  determinant,
    output logic                     not_square,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DIM_W-1:0]         cfg_data
);

    localparam int DEPTH = MAX_N * MAX_N;
    localparam int SA    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LCW   = $clog2(DEPTH + 1);
    localparam int CW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CCW   = $clog2(MAX_N + 1);
    localparam int MW    = MAX_N;

    typedef enum logic [2:0] {
        S_IDLE, S_NEXT, S_MAG, S_MUL_LO, S_MUL_HI, S_CMB, S_TERM, S_ACC
    } state_t;

    function automatic logic signed [DET_W-1:0] sat_add(
        input logic signed [DET_W-1:0] a, input logic signed [DET_W-1:0] b);
        logic [DET_W-1:0] s;
        s = a + b;
        if (a[DET_W-1] == b[DET_W-1] && s[DET_W-1] != a[DET_W-1])
            return a[DET_W-1] ? DET_MIN : DET_MAX;
        return s;
    endfunction

    function automatic logic signed [DET_W-1:0] sat_sub(
        input logic signed [DET_W-1:0] a, input logic signed [DET_W-1:0] b);
        logic [DET_W-1:0] d;
        d = a - b;
        if (a[DET_W-1] != b[DET_W-1] && d[DET_W-1] != a[DET_W-1])
            return a[DET_W-1] ? DET_MIN : DET_MAX;
        return d;
    endfunction

    function automatic logic [DIM_W-1:0] pop_count(input logic [MW-1:0] m);
        logic [DIM_W-1:0] n;
        n = '0;
        for (int b = 0; b < MW; b++)
            n = n + DIM_W'(m[b]);
        return n;
    endfunction

    // Configuration and effective dimensions.
    logic [DIM_W-1:0] rows_reg, cols_reg, rows_eff, cols_eff;

    always_comb
    begin
        rows_eff = rows_reg;
        cols_eff = cols_reg;
        if (rows_reg == '0) rows_eff = DIM_W'(1);
        else if (rows_reg > DIM_W'(MAX_N)) rows_eff = DIM_W'(MAX_N);
        if (cols_reg == '0) cols_eff = DIM_W'(1);
        else if (cols_reg > DIM_W'(MAX_N)) cols_eff = DIM_W'(MAX_N);
    end

    assign cfg_ready = 1'b1;

    // Control and datapath registers.
    state_t                   state_reg, state_next;
    logic [LCW-1:0]           load_count_reg, load_count_next;
    logic [DIM_W-1:0]         ld_row_reg, ld_row_next, ld_col_reg, ld_col_next;
    logic [MW-1:0]            mask_reg, mask_next;
    logic [CCW-1:0]           col_reg, col_next;
    logic                     parity_reg, parity_next;
    logic signed [DET_W-1:0]  acc_reg, acc_next;
    logic signed [DET_W-1:0]  det_reg, det_next;
    logic                     done_reg, done_next;
    logic                     ns_reg, ns_next;
    logic                     neg_reg, neg_next;
    logic [ELEM_W-1:0]        ma_reg, ma_next;
    logic [DET_W-1:0]         mb_reg, mb_next;
    logic [DET_W-1:0]         lo_reg, lo_next, mid_reg, mid_next;
    logic [DET_W-1:0]         q_reg, q_next;
    logic                     rem_reg, rem_next, ovf_reg, ovf_next;
    logic signed [DET_W-1:0]  term_reg, term_next;

    // Memories and their strobes.
    logic [ELEM_W-1:0]        store_mem [DEPTH];
    logic [DET_W-1:0]         dp_mem [2**MW];
    logic                     st_we, dp_we;
    logic [SA-1:0]            st_waddr, mat_raddr;
    logic [MW-1:0]            dp_raddr;
    logic [ELEM_W-1:0]        mat_rd_reg;
    logic [DET_W-1:0]         dp_rd_reg;
    logic                     dp_zero_reg;

    // Shared multiplier, low then high half of the minor magnitude.
    logic [DET_W-1:0]         product;
    logic [ELEM_W-1:0]        mul_b;

    assign mul_b   = (state_reg == S_MUL_LO) ? mb_reg[31:0] : mb_reg[63:32];
    assign product = DET_W'(ma_reg) * DET_W'(mul_b);

    // Sequencer helpers.
    logic [CW-1:0]    col_idx;
    logic [MW-1:0]    full_mask, sub_mask;
    logic [DIM_W-1:0] cur_row;
    logic [2*DIM_W-1:0] elem_limit;
    logic             accept;

    assign col_idx    = col_reg[CW-1:0];
    assign cur_row    = rows_eff - pop_count(mask_reg);
    assign elem_limit = {{DIM_W{1'b0}}, rows_eff} * {{DIM_W{1'b0}}, cols_eff};
    assign accept     = start && (state_reg == S_IDLE);

    always_comb
    begin
        for (int b = 0; b < MW; b++)
            full_mask[b] = (DIM_W'(b) < rows_eff);
        sub_mask          = mask_reg;
        sub_mask[col_idx] = 1'b0;
    end

    // Next-state logic.
    always_comb
    begin
        logic signed [ELEM_W-1:0] a;
        logic signed [DET_W-1:0]  b;
        logic [DET_W:0]           sum65;
        logic [32:0]              hi;
        logic [DET_W-1:0]         q1;

        state_next      = state_reg;
        load_count_next = load_count_reg;
        ld_row_next     = ld_row_reg;
        ld_col_next     = ld_col_reg;
        mask_next       = mask_reg;
        col_next        = col_reg;
        parity_next     = parity_reg;
        acc_next        = acc_reg;
        det_next        = det_reg;
        done_next       = 1'b0;
        ns_next         = ns_reg;
        neg_next        = neg_reg;
        ma_next         = ma_reg;
        mb_next         = mb_reg;
        lo_next         = lo_reg;
        mid_next        = mid_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        ovf_next        = ovf_reg;
        term_next       = term_reg;
        st_we           = 1'b0;
        dp_we           = 1'b0;
        st_waddr        = SA'(ld_row_reg * MAX_N + ld_col_reg);
        mat_raddr       = SA'(cur_row * MAX_N + col_idx);
        dp_raddr        = sub_mask;
        a               = '0;
        b               = '0;
        sum65           = '0;
        hi              = '0;
        q1              = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Store the element while the matrix has room.
                    if ((2*DIM_W)'(load_count_reg) < elem_limit)
                    begin
                        st_we           = 1'b1;
                        load_count_next = load_count_reg + LCW'(1);
                        if (ld_col_reg + DIM_W'(1) == cols_eff)
                        begin
                            ld_col_next = '0;
                            ld_row_next = ld_row_reg + DIM_W'(1);
                        end
                        else
                            ld_col_next = ld_col_reg + DIM_W'(1);
                    end
                    if (last_elem)
                    begin
                        load_count_next = '0;
                        ld_row_next     = '0;
                        ld_col_next     = '0;
                        if (rows_eff != cols_eff)
                        begin
                            det_next  = SENTINEL;
                            ns_next   = 1'b1;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next  = S_NEXT;
                            mask_next   = MW'(1);
                            col_next    = '0;
                            acc_next    = '0;
                            parity_next = 1'b0;
                        end
                    end
                end
            end

            S_NEXT:
            begin
                if (DIM_W'(col_reg) == rows_eff)
                begin
                    // Subset finished: keep its minor, move on or report.
                    dp_we = 1'b1;
                    if (mask_reg == full_mask)
                    begin
                        det_next   = acc_reg;
                        ns_next    = 1'b0;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mask_next   = mask_reg + MW'(1);
                        col_next    = '0;
                        acc_next    = '0;
                        parity_next = 1'b0;
                    end
                end
                else if (mask_reg[col_idx])
                    state_next = S_MAG;
                else
                    col_next = col_reg + CCW'(1);
            end

            S_MAG:
            begin
                a          = mat_rd_reg;
                b          = dp_zero_reg ? Q_ONE : dp_rd_reg;
                neg_next   = a[ELEM_W-1] ^ b[DET_W-1];
                ma_next    = a[ELEM_W-1] ? ELEM_W'(-a) : ELEM_W'(a);
                mb_next    = b[DET_W-1] ? DET_W'(-b) : DET_W'(b);
                state_next = S_MUL_LO;
            end

            S_MUL_LO:
            begin
                lo_next    = product;
                state_next = S_MUL_HI;
            end

            S_MUL_HI:
            begin
                mid_next   = product;
                state_next = S_CMB;
            end

            S_CMB:
            begin
                // Assemble the 96-bit product and drop 16 fraction bits.
                sum65      = {1'b0, lo_reg} + {1'b0, mid_reg[31:0], 32'b0};
                hi         = {1'b0, mid_reg[63:32]} + 33'(sum65[DET_W]);
                ovf_next   = |hi[32:16];
                q_next     = {hi[15:0], sum65[63:16]};
                rem_next   = |sum65[15:0];
                state_next = S_TERM;
            end

            S_TERM:
            begin
                if (ovf_reg)
                    term_next = neg_reg ? DET_MIN : DET_MAX;
                else if (neg_reg)
                begin
                    q1 = q_reg + DET_W'(rem_reg);
                    term_next = q1[DET_W-1] ? DET_MIN : -$signed(q1);
                end
                else
                    term_next = q_reg[DET_W-1] ? DET_MAX : $signed(q_reg);
                state_next = S_ACC;
            end

            S_ACC:
            begin
                acc_next    = parity_reg ? sat_sub(acc_reg, term_reg)
                                         : sat_add(acc_reg, term_reg);
                parity_next = ~parity_reg;
                col_next    = col_reg + CCW'(1);
                state_next  = S_NEXT;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rows_reg       <= DIM_W'(1);
            cols_reg       <= DIM_W'(1);
            load_count_reg <= '0;
            ld_row_reg     <= '0;
            ld_col_reg     <= '0;
            mask_reg       <= '0;
            col_reg        <= '0;
            parity_reg     <= 1'b0;
            acc_reg        <= '0;
            det_reg        <= '0;
            done_reg       <= 1'b0;
            ns_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            ld_row_reg     <= ld_row_next;
            ld_col_reg     <= ld_col_next;
            mask_reg       <= mask_next;
            col_reg        <= col_next;
            parity_reg     <= parity_next;
            acc_reg        <= acc_next;
            det_reg        <= det_next;
            done_reg       <= done_next;
            ns_reg         <= ns_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_NUM_ROWS) rows_reg <= cfg_data;
                if (cfg_index == REG_NUM_COLS) cols_reg <= cfg_data;
            end
        end
    end

    // Arithmetic payload registers.
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        lo_reg   <= lo_next;
        mid_reg  <= mid_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        ovf_reg  <= ovf_next;
        term_reg <= term_next;
    end

    // Matrix store and minor table, registered reads.
    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= elem_value;
        mat_rd_reg <= store_mem[mat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dp_we)
            dp_mem[mask_reg] <= acc_reg;
        dp_rd_reg   <= dp_mem[dp_raddr];
        dp_zero_reg <= (dp_raddr == '0);
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign determinant = det_reg;
    assign not_square  = ns_reg;

    // A non-square result always carries the sentinel.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && not_square |-> determinant == SENTINEL)
        else $error("not_square result without sentinel");

    // The block only goes busy on a closing element.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && last_elem))
        else $error("busy without closing element");

    // A computed determinant ends a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !not_square |-> $past(busy) && !busy)
        else $error("determinant outside a busy period");

    // The column scan never runs past the matrix width.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> DIM_W'(col_reg) <= rows_eff)
        else $error("column index beyond matrix");

endmodule

[test/cdet_checker.sv]
// Checker for the cofactor determinant block: watches the configuration,
// element and result channels, predicts each determinant and compares.
// Depends on cdet_pkg.
module cdet_checker
    import cdet_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic signed [ELEM_W-1:0] elem_value,
    input  logic                     last_elem,
    input  logic                     done,
    input  logic signed [DET_W-1:0]  determinant,
    input  logic                     not_square,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DIM_W-1:0]         cfg_data,
    output int                       errors,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N = MAX_N_DEFAULT;

    typedef struct {
        logic signed [DET_W-1:0] det;
        logic                    ns;
    } det_result_t;

    logic [ELEM_W-1:0] elem_store [N*N];
    int                elems_loaded;
    logic [DIM_W-1:0]  rows_reg;
    logic [DIM_W-1:0]  cols_reg;
    det_result_t       det_queue[$];

    assign pending = det_queue.size();

    // Clamp a dimension register to its effective range.
    function automatic int clamp_dim(logic [DIM_W-1:0] v);
        if (v < 1)
            return 1;
        if (v > N)
            return N;
        return int'(v);
    endfunction

    function automatic logic signed [DET_W-1:0] sat_sum(logic signed [DET_W-1:0] a,
                                                        logic signed [DET_W-1:0] b,
                                                        logic subtract);
        logic signed [DET_W:0] s;
        if (subtract)
            s = {a[DET_W-1], a} - {b[DET_W-1], b};
        else
            s = {a[DET_W-1], a} + {b[DET_W-1], b};
        if (s[DET_W] != s[DET_W-1])
            return s[DET_W] ? DET_MIN : DET_MAX;
        return s[DET_W-1:0];
    endfunction

    // Q16.16 product, floored, saturated to 64 bits. The rounding increment
    // of a negative product wraps within 64 bits.
    function automatic logic signed [DET_W-1:0] q_product(logic signed [DET_W-1:0] a,
                                                          logic signed [DET_W-1:0] b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        logic [64:0]  q;
        logic         neg;
        neg = a[DET_W-1] ^ b[DET_W-1];
        ma = a[DET_W-1] ? -a : a;
        mb = b[DET_W-1] ? -b : b;
        p = {64'd0, ma} * {64'd0, mb};
        if (p[127:80] != 0)
            return neg ? DET_MIN : DET_MAX;
        q = {1'b0, p[79:16]};
        if (neg)
        begin
            if (p[15:0] != 0)
                q = {1'b0, 64'(q[63:0] + 64'd1)};
            if (q >= 65'h0_8000_0000_0000_0000)
                return DET_MIN;
            return -$signed(q[63:0]);
        end
        if (q > 65'h0_7FFF_FFFF_FFFF_FFFF)
            return DET_MAX;
        return q[63:0];
    endfunction

    // Determinant of the minor starting at row over the columns set in col_mask.
    function automatic logic signed [DET_W-1:0] minor_value(int row, logic [N-1:0] col_mask);
        logic signed [DET_W-1:0] acc;
        logic signed [DET_W-1:0] term;
        logic signed [DET_W-1:0] elem;
        int                      k;
        acc = 0;
        k = 0;
        for (int c = 0; c < N; c++)
        begin
            if (col_mask[c])
            begin
                elem = {{(DET_W-ELEM_W){elem_store[row*N+c][ELEM_W-1]}},
                        elem_store[row*N+c]};
                if ($countones(col_mask) == 1)
                    return elem;
                term = q_product(elem, minor_value(row + 1, col_mask & ~(N'(1) << c)));
                acc = sat_sum(acc, term, k[0]);
                k++;
            end
        end
        return acc;
    endfunction

    // Track configuration and elements, queue the expected determinant.
    always @(posedge clk or negedge rst_n)
    begin
        int          r;
        int          c;
        det_result_t res;
        if (!rst_n)
        begin
            elems_loaded <= 0;
            rows_reg <= 1;
            cols_reg <= 1;
            errors <= 0;
            det_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_NUM_ROWS)
                    rows_reg <= cfg_data;
                else if (cfg_index == REG_NUM_COLS)
                    cols_reg <= cfg_data;
            end

            // Compare a result strobe with the oldest expected determinant.
            if (done)
            begin
                if (det_queue.size() == 0)
                begin
                    $display("%0t: unexpected result det=%0d not_square=%0b",
                             $realtime, determinant, not_square);
                    errors <= errors + 1;
                end
                else
                begin
                    res = det_queue.pop_front();
                    if (res.det !== determinant || res.ns !== not_square)
                    begin
                        $display({"%0t: mismatch expected det=%0d not_square=%0b,",
                                  " actual det=%0d not_square=%0b"},
                                 $realtime, res.det, res.ns, determinant, not_square);
                        errors <= errors + 1;
                    end
                end
            end

            // An element transaction: store it, and close the matrix on the last mark.
            if (start && !busy)
            begin
                r = clamp_dim(rows_reg);
                c = clamp_dim(cols_reg);
                if (elems_loaded < r * c)
                    elem_store[(elems_loaded / c) * N + elems_loaded % c] = elem_value;
                elems_loaded <= elems_loaded + 1;
                if (last_elem)
                begin
                    elems_loaded <= 0;
                    if (r != c)
                    begin
                        res.det = SENTINEL;
                        res.ns = 1'b1;
                    end
                    else
                    begin
                        res.det = minor_value(0, N'((1 << r) - 1));
                        res.ns = 1'b0;
                    end
                    det_queue.push_back(res);
                end
            end
        end
    end

endmodule

[test/tb.sv]
// Testbench top for the cofactor determinant block: clock, reset, element and
// configuration stimulus, and the verdict. Depends on cdet_pkg, cdet_checker.
module tb
    import cdet_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [ELEM_W-1:0] elem_value;
    logic                     last_elem;
    logic                     done;
    logic signed [DET_W-1:0]  determinant;
    logic                     not_square;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DIM_W-1:0]         cfg_data;
    int                       errors;
    int                       pending;
    int                       idle_pct;
    int                       items_sent;

    cofactor_determinant dut (.*);
    cdet_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Guard against a hung block.
    initial
    begin
        #8ms;
        $display("cofactor_determinant regression: fail");
        $finish;
    end

    // Send one element transaction; start stays high on return.
    task automatic send_elem(logic [ELEM_W-1:0] v, logic last);
        logic accepted;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        start <= 1'b1;
        elem_value <= v;
        last_elem <= last;
        do
        begin
            @(negedge clk);
            accepted = !busy;
            @(posedge clk);
        end
        while (!accepted);
        items_sent++;
    endtask

    // Hold off until every determinant has come back and the block is quiet.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Write both shape registers while idle.
    task automatic set_shape(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c);
        logic accepted;
        settle();
        for (int i = 0; i < 2; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? REG_NUM_ROWS : REG_NUM_COLS;
            cfg_data <= (i == 0) ? r : c;
            do
            begin
                @(negedge clk);
                accepted = cfg_ready;
                @(posedge clk);
            end
            while (!accepted);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ELEM_W-1:0] pick_elem();
        logic [ELEM_W-1:0] extremes [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                            32'h0001_0000, 32'hFFFF_0000};
        case ($urandom_range(4))
            0: return $urandom;
            1: return extremes[$urandom_range(4)];
            2: return ($urandom_range(8) - 4) * 32'h1_0000 + $urandom_range(16'hFFFF);
            3: return $urandom_range(512) - 256;
            default: return (($urandom_range(400) - 200) << 16);
        endcase
    endfunction

    // Stimulus: directed matrices, then random shapes over idling phases.
    initial
    begin
        int pcts [4] = '{0, 75, 0, 13};
        logic [ELEM_W-1:0] directed [16] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                            32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                                            32'h8000_0000, 32'h1, 32'hFFFF_FFFF,
                                            32'h0002_8000, 32'h8000_0000, 32'h7FFF_FFFF,
                                            32'h0003_0000, 32'hFFFE_0000,
                                            32'h5555_5555, 32'hAAAA_AAAA};
        int r;
        int c;
        int n;
        int len;
        rst_n = 1'b0;
        start = 1'b0;
        elem_value = '0;
        last_elem = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_NUM_ROWS;
        cfg_data = '0;
        idle_pct = 0;
        items_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A full 4x4 load first, so every store entry has been written.
        set_shape(DIM_W'(4), DIM_W'(4));
        for (int i = 0; i < 16; i++)
            send_elem(directed[i], i == 15);
        set_shape(DIM_W'(1), DIM_W'(1));
        send_elem(32'h8000_0000, 1'b1);
        send_elem(32'h7FFF_FFFF, 1'b1);
        set_shape(DIM_W'(2), DIM_W'(3));
        for (int i = 0; i < 6; i++)
            send_elem(pick_elem(), i == 5);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = pcts[ph];
            settle();
            while (items_sent < 25 + (ph + 1) * 200)
            begin
                if ($urandom_range(5) == 0)
                begin
                    if ($urandom_range(4) == 0)
                        set_shape(DIM_W'($urandom_range(7)), DIM_W'($urandom_range(7)));
                    else
                    begin
                        n = $urandom_range(1, 4);
                        if ($urandom_range(2) == 0)
                            set_shape(DIM_W'(n), DIM_W'($urandom_range(1, 4)));
                        else
                            set_shape(DIM_W'(n), DIM_W'(n));
                    end
                end
                r = chk.clamp_dim(chk.rows_reg);
                c = chk.clamp_dim(chk.cols_reg);
                n = r * c;
                case ($urandom_range(9))
                    0: len = $urandom_range(1, n);
                    1: len = n + $urandom_range(1, 3);
                    default: len = n;
                endcase
                for (int i = 0; i < len; i++)
                    send_elem(pick_elem(), i == len - 1);
            end
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("cofactor_determinant regression: pass");
        else
            $display("cofactor_determinant regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/core/cdet_pkg.sv
rtl/core/cofactor_determinant.sv
test/cdet_checker.sv
test/tb.sv
